// ----- sv/tti_pkg.sv -----
package tti_pkg;

  localparam int SPEED_W   = 16;
  localparam int SPACING_W = 10;
  localparam int RECIP_W   = 25;
  localparam int REM_W     = SPEED_W + 1;
  localparam int ACC_W     = 40;
  localparam int TERM_W    = RECIP_W + 1;
  localparam int PROD_W    = ACC_W + SPACING_W;
  localparam int TIME_W    = 48;
  localparam int STEP_W    = 5;

  localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(50);
  localparam logic [RECIP_W-1:0]   RECIP_NUM     = RECIP_W'(1) << (RECIP_W - 1);
  localparam logic [STEP_W-1:0]    DIV_STEPS     = STEP_W'(RECIP_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  typedef struct packed {
    logic load;
    logic div_step;
    logic acc;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } status_t;

endpackage

// ----- sv/tti_ctrl.sv -----
module tti_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tti_pkg::status_t status,
  output tti_pkg::cmd_t    cmd
);
  import tti_pkg::*;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == DIV_STEPS - STEP_W'(1)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- sv/tti_dp.sv -----
module tti_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tti_pkg::cmd_t                 cmd,
  output tti_pkg::status_t              status,
  input  logic [tti_pkg::SPEED_W-1:0]   speed,
  input  logic                          last_sample,
  input  logic                          cfg_wr_en,
  input  logic [tti_pkg::SPACING_W-1:0] cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tti_pkg::TIME_W-1:0]    travel_time,
  output logic                          overflowed
);
  import tti_pkg::*;

  logic [SPACING_W-1:0] spacing;
  logic [SPEED_W-1:0]   divisor;
  logic [RECIP_W-1:0]   num;
  logic [REM_W-1:0]     rem;
  logic [RECIP_W-1:0]   quot;
  logic                 last_r;
  logic [ACC_W-1:0]     acc;
  logic                 awaiting_first;
  logic                 sat_seen;
  logic [PROD_W-1:0]    prod;

  logic [REM_W-1:0]     rem_sh;
  logic                 fits;
  logic [TERM_W-1:0]    term;
  logic [ACC_W:0]       sum;
  logic [TIME_W:0]      half;

  assign rem_sh = {rem[REM_W-2:0], num[RECIP_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_comb begin
    if (awaiting_first && last_r) begin
      term = '0;
    end else if (awaiting_first || last_r) begin
      term = {1'b0, quot};
    end else begin
      term = {quot, 1'b0};
    end
  end

  assign sum  = {1'b0, acc} + (ACC_W + 1)'(term);
  assign half = prod[PROD_W-1:1];

  assign status.last     = last_r;
  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (cfg_wr_en) begin
      spacing <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= (speed == '0) ? SPEED_W'(1) : speed;
      last_r  <= last_sample;
      num     <= RECIP_NUM;
      rem     <= '0;
      quot    <= '0;
    end else if (cmd.div_step) begin
      num  <= {num[RECIP_W-2:0], 1'b0};
      rem  <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      quot <= {quot[RECIP_W-2:0], fits};
    end
    if (cmd.mul) begin
      prod <= acc * spacing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc            <= '0;
      awaiting_first <= 1'b1;
      sat_seen       <= 1'b0;
    end else if (cmd.acc) begin
      awaiting_first <= 1'b0;
      if (sum[ACC_W]) begin
        acc      <= '1;
        sat_seen <= 1'b1;
      end else begin
        acc <= sum[ACC_W-1:0];
      end
    end else if (cmd.out_load) begin
      acc            <= '0;
      awaiting_first <= 1'b1;
      sat_seen       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (half[TIME_W]) begin
        travel_time <= '1;
        overflowed  <= 1'b1;
      end else begin
        travel_time <= half[TIME_W-1:0];
        overflowed  <= sat_seen;
      end
    end
  end

endmodule

// ----- sv/travel_time_trapezoid_integrator_unit.sv -----
// Channel   Direction  Beat contents
// s_axis    in         tdata[15:0] speed (Q8.8), tlast last_sample
// m_axis    out        tdata[47:0] travel_time (Q32.16), tuser overflowed
// cfg       in         cfg_wr_data[9:0] sample_spacing, written when cfg_wr_en
//
// An inner sample is accepted, passes through the bit-serial reciprocal
// divider and is then accumulated. A last sample adds a multiply step and an
// output load step.
// The output register lets the next sample be accepted while a result waits;
// a stalled m_axis only holds the block once a second result is ready.
// Reset is synchronous and restores a spacing of 50 and an empty path.
module travel_time_trapezoid_integrator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] speed
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // [47:0] travel_time
  output logic                          m_axis_tuser,  // [0] overflowed
  input  logic                          cfg_wr_en,
  input  logic [tti_pkg::SPACING_W-1:0] cfg_wr_data
);
  import tti_pkg::*;

  cmd_t    cmd;
  status_t status;

  tti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tti_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .speed       (s_axis_tdata),
    .last_sample (s_axis_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .travel_time (m_axis_tdata),
    .overflowed  (m_axis_tuser)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken result");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("controller issued more than one command");

endmodule

// ----- test/travel_time_trapezoid_integrator_unit_tb.sv -----
`timescale 1ns / 100ps

module travel_time_trapezoid_integrator_unit_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam int CHUNK_BEATS   = 105;
  localparam int PLAN_ROWS     = 26;

  typedef enum logic {STEP_BEAT, STEP_SPACING} plan_step_t;

  typedef struct packed {
    logic [47:0] travel_time;
    logic        overflowed;
  } path_result_t;

  typedef struct packed {
    plan_step_t                    kind;
    logic [15:0]                   speed;
    logic                          last;
    logic [tti_pkg::SPACING_W-1:0] spacing;
    logic                          fixed;
    logic [47:0]                   want_time;
    logic                          want_ovf;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata;  // [15:0] speed
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [47:0]                   m_axis_tdata;  // [47:0] travel_time
  logic                          m_axis_tuser;  // [0] overflowed
  logic                          cfg_wr_en;
  logic [tti_pkg::SPACING_W-1:0] cfg_wr_data;

  logic [tti_pkg::ACC_W-1:0]     path_sum = '0;
  logic                          path_opening = 1'b1;
  logic                          path_saturated = 1'b0;
  logic [tti_pkg::SPACING_W-1:0] spacing_m = tti_pkg::SPACING_RESET;

  path_result_t pending_times[$];
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           spacing_picks = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{STEP_BEAT,    16'd1,     1'b1, 10'd0,    1'b1, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd65535, 1'b1, 10'd0,    1'b1, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd0,     1'b1, 10'd0,    1'b1, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd1,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd1,     1'b1, 10'd0,    1'b1, 48'd838860800,   1'b0},
    '{STEP_BEAT,    16'd0,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd0,     1'b1, 10'd0,    1'b1, 48'd838860800,   1'b0},
    '{STEP_BEAT,    16'd65535, 1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd65535, 1'b1, 10'd0,    1'b1, 48'd12800,       1'b0},
    '{STEP_SPACING, 16'd0,     1'b0, 10'd1023, 1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd1,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd1,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd1,     1'b1, 10'd0,    1'b1, 48'd34326183936, 1'b0},
    '{STEP_SPACING, 16'd0,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd300,   1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'h8000,  1'b1, 10'd0,    1'b1, 48'd0,           1'b0},
    '{STEP_SPACING, 16'd0,     1'b0, 10'd1,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd3,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'd7,     1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_SPACING, 16'd0,     1'b0, 10'd777,  1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'h5555,  1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'hAAAA,  1'b1, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_SPACING, 16'd0,     1'b0, 10'd1,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'h00FF,  1'b0, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_BEAT,    16'h0100,  1'b1, 10'd0,    1'b0, 48'd0,           1'b0},
    '{STEP_SPACING, 16'd0,     1'b0, 10'd50,   1'b0, 48'd0,           1'b0}
  };

  travel_time_trapezoid_integrator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Weights each reciprocal by its place in the path and closes the path on its last sample.
  task automatic integrate_sample(input logic [15:0] speed, input logic last,
                                  output logic emitted, output path_result_t res);
    logic [24:0] recip;
    logic [25:0] term;
    logic [40:0] sum;
    logic [49:0] prod;
    logic [48:0] halved;
    recip = 25'h100_0000 / ((speed == 16'd0) ? 25'd1 : 25'(speed));
    if (path_opening && last) begin
      term = '0;
    end else if (path_opening || last) begin
      term = 26'(recip);
    end else begin
      term = {recip, 1'b0};
    end
    sum = 41'(path_sum) + 41'(term);
    if (sum[40]) begin
      path_sum = '1;
      path_saturated = 1'b1;
    end else begin
      path_sum = sum[39:0];
    end
    path_opening = 1'b0;
    emitted = last;
    res = '0;
    if (last) begin
      prod = 50'(path_sum) * 50'(spacing_m);
      halved = prod[49:1];
      res.overflowed = path_saturated;
      if (halved[48]) begin
        res.travel_time = '1;
        res.overflowed = 1'b1;
      end else begin
        res.travel_time = halved[47:0];
      end
      path_sum = '0;
      path_opening = 1'b1;
      path_saturated = 1'b0;
    end
  endtask

  task automatic send_beat(input logic [15:0] speed, input logic last,
                           input logic fixed, input path_result_t fixed_res);
    logic emitted;
    path_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= speed;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    integrate_sample(speed, last, emitted, res);
    if (emitted) pending_times.insert(pending_times.size(), fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_times.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_spacing(input logic [tti_pkg::SPACING_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    spacing_m = value;
  endtask

  function automatic logic [15:0] pick_speed();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'd0;
    if (roll <= 2) return 16'($urandom_range(1, 16));
    if (roll == 3) return 16'($urandom_range(16'hFF00, 16'hFFFF));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_paths(input int beats);
    int sent;
    int len;
    int roll;
    int j;
    path_result_t none;
    sent = 0;
    none = '0;
    while (sent < beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        len = 1;
      end else if (roll < 75) begin
        len = $urandom_range(2, 8);
      end else if (roll < 95) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(41, 200);
      end
      for (j = 0; j < len; j++) send_beat(pick_speed(), j == len - 1, 1'b0, none);
      sent += len;
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  task automatic run_random_phase();
    int k;
    logic [tti_pkg::SPACING_W-1:0] value;
    for (k = 0; k < 6; k++) begin
      unique case (spacing_picks)
        0: value = 10'd1023;
        1: value = 10'd0;
        2: value = 10'd1;
        default: value = 10'($urandom_range(0, 1023));
      endcase
      spacing_picks++;
      set_spacing(value);
      send_paths(CHUNK_BEATS);
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    path_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_times.size() == 0) begin
        report_mismatch($sformatf("unexpected result time=%0d ovf=%0b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_times.pop_front();
        if (m_axis_tdata !== want.travel_time) begin
          report_mismatch($sformatf("travel_time got %0d want %0d",
                                    m_axis_tdata, want.travel_time));
        end
        if (m_axis_tuser !== want.overflowed) begin
          report_mismatch($sformatf("overflowed got %0b want %0b",
                                    m_axis_tuser, want.overflowed));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int i;
    path_result_t fixed_res;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 14;
    recv_idle_pct = 82;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == STEP_SPACING) begin
        set_spacing(plan[i].spacing);
      end else begin
        fixed_res.travel_time = plan[i].want_time;
        fixed_res.overflowed = plan[i].want_ovf;
        send_beat(plan[i].speed, plan[i].last, plan[i].fixed, fixed_res);
      end
    end

    run_random_phase();
    send_idle_pct = 82;
    recv_idle_pct = 14;
    run_random_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase();

    wait_drained();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
